/* src/qte_pkg.sv */
`default_nettype none
package qte_pkg;

  localparam int ANG_W  = 34;
  localparam int VEC_W  = 58;
  localparam int TERM_W = 36;
  localparam int ROOT_W = 58;
  localparam int SQRT_CELLS = 29;
  localparam int PASS_W = 5 * TERM_W + 1;

  localparam logic signed [TERM_W-1:0] ONE_Q28     = TERM_W'(64'sd268435456);
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = ANG_W'(64'sd1686629713);
  localparam logic signed [16:0]       PI_Q13      = 17'sd25736;
  localparam logic signed [16:0]       HALF_PI_Q13 = 17'sd12868;

  typedef struct packed {
    logic zero;
    logic clamp;
    logic neg;
  } flags_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
    flags_t                  flags;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/qte_sqrt_cell.sv */
`default_nettype none
module qte_sqrt_cell #(
  parameter int BIT_POS = 56
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             en_i,
  input  wire                             valid_i,
  input  wire [qte_pkg::ROOT_W-1:0]       rem_i,
  input  wire [qte_pkg::ROOT_W-1:0]       root_i,
  input  wire [qte_pkg::PASS_W-1:0]       pass_i,
  output logic                            valid_o,
  output logic [qte_pkg::ROOT_W-1:0]      rem_o,
  output logic [qte_pkg::ROOT_W-1:0]      root_o,
  output logic [qte_pkg::PASS_W-1:0]      pass_o
);

  localparam logic [qte_pkg::ROOT_W-1:0] BIT = qte_pkg::ROOT_W'(1) << BIT_POS;

  logic [qte_pkg::ROOT_W-1:0] trial;
  logic [qte_pkg::ROOT_W-1:0] rem_d, root_d;

  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + BIT;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      pass_o <= pass_i;
    end
  end

endmodule
`default_nettype wire

/* src/qte_cordic_cell.sv */
`default_nettype none
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  qte_pkg::lanes_t        lanes_i,
  output logic                   valid_o,
  output qte_pkg::lanes_t        lanes_o
);

  localparam logic signed [qte_pkg::ANG_W-1:0] ATAN = qte_pkg::atan_q30(STAGE);

  qte_pkg::lanes_t lanes_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lanes_d[l].flags = lanes_i[l].flags;
      if (!lanes_i[l].y[qte_pkg::VEC_W-1]) begin
        lanes_d[l].x   = lanes_i[l].x + (lanes_i[l].y >>> STAGE);
        lanes_d[l].y   = lanes_i[l].y - (lanes_i[l].x >>> STAGE);
        lanes_d[l].ang = lanes_i[l].ang + ATAN;
      end else begin
        lanes_d[l].x   = lanes_i[l].x - (lanes_i[l].y >>> STAGE);
        lanes_d[l].y   = lanes_i[l].y + (lanes_i[l].x >>> STAGE);
        lanes_d[l].ang = lanes_i[l].ang - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_o <= lanes_d;
    end
  end

endmodule
`default_nettype wire

/* src/quaternion_to_euler_angles.sv */
`default_nettype none
// Quaternion (x, y, z, w, signed Q2.14) to roll and yaw (signed Q3.13) and pitch (signed
// Q2.13), in radians, ZYX order. Fully pipelined: one quaternion is taken per cycle unless
// the output stalls. Registers hold products, sums, the pitch sine square and the radicand;
// a 29-cell square-root chain (one root bit per cell) gives the pitch cosine term, then a
// pre-rotation register, the CORDIC cells (at most 32 cells, three vectors rotated side by
// side) and a rounding register. A stalled output holds the whole pipeline. Pitch saturates
// to plus or minus half pi with pitch_clamped set when the sine term reaches one in magnitude.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire signed [15:0]  quat_x_i,
  input  wire signed [15:0]  quat_y_i,
  input  wire signed [15:0]  quat_z_i,
  input  wire signed [15:0]  quat_w_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);

  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int TW = qte_pkg::TERM_W;
  localparam int RW = qte_pkg::ROOT_W;
  localparam int SQRT_N = qte_pkg::SQRT_CELLS;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // products
  logic v1_q;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  // terms
  logic v2_q;
  logic signed [TW-1:0] sr_q, cr_q, sp_q, sy_q, cy_q;
  // pitch square
  logic v3_q, clamp3_q;
  logic signed [TW-1:0] sr3_q, cr3_q, sp3_q, sy3_q, cy3_q;
  logic [57:0] sq3_q;
  logic signed [28:0] sp29;
  logic clamp_d;
  // radicand
  logic v4_q;
  logic [RW-1:0] rad4_q;
  logic [qte_pkg::PASS_W-1:0] pass4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign sp29    = sp_q[28:0];
  assign clamp_d = (sp_q >= qte_pkg::ONE_Q28) || (sp_q <= -qte_pkg::ONE_Q28);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;

      sr_q <= (TW'(wx_q) + TW'(yz_q)) <<< 1;
      cr_q <= qte_pkg::ONE_Q28 - ((TW'(xx_q) + TW'(yy_q)) <<< 1);
      sp_q <= (TW'(wy_q) - TW'(zx_q)) <<< 1;
      sy_q <= (TW'(wz_q) + TW'(xy_q)) <<< 1;
      cy_q <= qte_pkg::ONE_Q28 - ((TW'(yy_q) + TW'(zz_q)) <<< 1);

      sq3_q    <= 58'(sp29 * sp29);
      clamp3_q <= clamp_d;
      sr3_q    <= sr_q;
      cr3_q    <= cr_q;
      sp3_q    <= sp_q;
      sy3_q    <= sy_q;
      cy3_q    <= cy_q;

      rad4_q  <= (RW'(1) << 56) - RW'(sq3_q);
      pass4_q <= {clamp3_q, sp3_q, sr3_q, cr3_q, sy3_q, cy3_q};
    end
  end

  // square-root chain
  logic                       sq_v    [SQRT_N:0];
  logic [RW-1:0]              sq_rem  [SQRT_N:0];
  logic [RW-1:0]              sq_root [SQRT_N:0];
  logic [qte_pkg::PASS_W-1:0] sq_pass [SQRT_N:0];

  assign sq_v[0]    = v4_q;
  assign sq_rem[0]  = rad4_q;
  assign sq_root[0] = '0;
  assign sq_pass[0] = pass4_q;

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT_POS(56 - 2 * k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_v[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .pass_i (sq_pass[k]),
      .valid_o(sq_v[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .pass_o (sq_pass[k+1])
    );
  end

  // pre-rotation
  function automatic qte_pkg::lane_t prerot(input logic signed [TW-1:0] num,
                                            input logic signed [TW-1:0] den,
                                            input logic clamp);
    qte_pkg::lane_t r;
    logic signed [qte_pkg::VEC_W-1:0] xs, ys;
    xs = qte_pkg::VEC_W'(den) <<< 20;
    ys = qte_pkg::VEC_W'(num) <<< 20;
    r.flags.zero  = (num == '0) && (den == '0);
    r.flags.clamp = clamp;
    r.flags.neg   = num[TW-1];
    if (xs[qte_pkg::VEC_W-1]) begin
      if (!ys[qte_pkg::VEC_W-1]) begin
        r.x   = ys;
        r.y   = -xs;
        r.ang = qte_pkg::HALF_PI_Q30;
      end else begin
        r.x   = -ys;
        r.y   = xs;
        r.ang = -qte_pkg::HALF_PI_Q30;
      end
    end else begin
      r.x   = xs;
      r.y   = ys;
      r.ang = '0;
    end
    return r;
  endfunction

  logic                 p_clamp;
  logic signed [TW-1:0] p_sp, p_sr, p_cr, p_sy, p_cy, p_cp;
  assign {p_clamp, p_sp, p_sr, p_cr, p_sy, p_cy} = sq_pass[SQRT_N];
  assign p_cp = TW'(sq_root[SQRT_N][28:0]);

  logic            cv [NSTG:0];
  qte_pkg::lanes_t cl [NSTG:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= sq_v[SQRT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl[0][0] <= prerot(p_sr, p_cr, 1'b0);
      cl[0][1] <= prerot(p_sp, p_cp, p_clamp);
      cl[0][2] <= prerot(p_sy, p_cy, 1'b0);
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_cordic
    qte_cordic_cell #(.STAGE(s)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(cv[s]),
      .lanes_i(cl[s]),
      .valid_o(cv[s+1]),
      .lanes_o(cl[s+1])
    );
  end

  // rounding and saturation
  function automatic logic signed [16:0] rnd_sat(input qte_pkg::lane_t ln,
                                                 input logic signed [16:0] lim);
    logic signed [qte_pkg::ANG_W-1:0] a;
    logic signed [16:0] r;
    a = ln.ang + qte_pkg::ANG_W'(64'sd65536);
    r = a[33:17];
    if (ln.flags.zero) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [16:0] roll_r, pitch_r, yaw_r;
  qte_pkg::lane_t     lp;

  always_comb begin
    lp      = cl[NSTG][1];
    roll_r  = rnd_sat(cl[NSTG][0], qte_pkg::PI_Q13);
    yaw_r   = rnd_sat(cl[NSTG][2], qte_pkg::PI_Q13);
    if (lp.flags.clamp) begin
      pitch_r = lp.flags.neg ? -qte_pkg::HALF_PI_Q13 : qte_pkg::HALF_PI_Q13;
    end else begin
      pitch_r = rnd_sat(lp, qte_pkg::HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= cv[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o    <= roll_r[15:0];
      pitch_angle_o   <= pitch_r[14:0];
      yaw_angle_o     <= yaw_r[15:0];
      pitch_clamped_o <= lp.flags.clamp;
    end
  end

endmodule
`default_nettype wire

/* dv/testbench.sv */
module testbench;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 35;
  localparam int RANDOM_ITEMS = 1510;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic pitch_clamped_o;

  euler_t expected_angles[$];
  int mismatches = 0;
  int unexpected = 0;
  int sent = 0;
  int received = 0;
  int clamp_hits = 0;
  longint cycles = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_receiver = 1'b0;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i), .quat_z_i(quat_z_i), .quat_w_i(quat_w_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .roll_angle_o(roll_angle_o), .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o(yaw_angle_o), .pitch_clamped_o(pitch_clamped_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1, 0, 0};
    return tab[i];
  endfunction

  function automatic longint vector_angle(longint num, longint den);
    longint vx, vy, ang, t;
    int n;
    if (num == 0 && den == 0) return 0;
    vx = den <<< 20;
    vy = num <<< 20;
    ang = 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; ang = 1686629713;
      end else begin
        vx = -vy; vy = t; ang = -1686629713;
      end
    end
    n = STAGES > 32 ? 32 : STAGES;
    for (int i = 0; i < n; i++) begin
      t = vx;
      if (vy >= 0) begin
        vx += shr_floor(vy, i); vy -= shr_floor(t, i); ang += atan_step(i);
      end else begin
        vx -= shr_floor(vy, i); vy += shr_floor(t, i); ang -= atan_step(i);
      end
    end
    return shr_floor(ang + (64'sd1 << 16), 17);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic euler_t quat_to_euler(longint x, longint y, longint z, longint w);
    euler_t r;
    longint one, s, c;
    one = 64'sd1 << 28;
    r.roll = 16'(clip(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 25736));
    s = 2 * (w * y - z * x);
    if (s >= one || s <= -one) begin
      r.clamped = 1'b1;
      r.pitch = s > 0 ? 15'sd12868 : -15'sd12868;
    end else begin
      r.clamped = 1'b0;
      c = root_floor(longint'(one * one) - longint'(s * s));
      r.pitch = 15'(clip(vector_angle(s, c), 12868));
    end
    s = 2 * (w * z + x * y);
    c = one - 2 * (y * y + z * z);
    r.yaw = 16'(clip(vector_angle(s, c), 25736));
    return r;
  endfunction

  task automatic send_quat(logic signed [15:0] x, y, z, w);
    int gap;
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_x_i <= x; quat_y_i <= y; quat_z_i <= z; quat_w_i <= w;
    expected_angles.push_back(quat_to_euler(x, y, z, w));
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_sending();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  task automatic test_extremes();
    logic signed [15:0] v[5] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585};
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, -11585, 0, 11585);
    send_quat(11585, 0, 11585, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    for (int i = 0; i < 10; i++)
      send_quat(v[i % 5], v[(i + 2) % 5], v[(i + 3) % 5], v[(i + 1) % 5]);
  endtask

  task automatic test_backpressure();
    hold_receiver = 1'b1;
    for (int i = 0; i < 120; i++)
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    hold_receiver = 1'b0;
  endtask

  task automatic test_random();
    logic signed [15:0] a, b, c, d;
    real n;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 200) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
      case ($urandom_range(0, 9))
        0: begin
          a = 16'($urandom); b = 16'($urandom); c = 16'($urandom); d = 16'($urandom);
        end
        1, 2, 3, 4, 5: begin
          n = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c + real'(d) * d);
          if (n > 1.0) begin
            a = 16'($rtoi(a * 16384.0 / n)); b = 16'($rtoi(b * 16384.0 / n));
            c = 16'($rtoi(c * 16384.0 / n)); d = 16'($rtoi(d * 16384.0 / n));
          end
        end
        6: begin
          // near gimbal lock
          a = 16'($urandom_range(0, 200)) - 16'sd100; c = 16'($urandom_range(0, 200)) - 16'sd100;
          b = 16'sd11585 + 16'($urandom_range(0, 60)) - 16'sd30;
          d = $urandom_range(0, 1) ? b : -b;
        end
        default: ;
      endcase
      send_quat(a, b, c, d);
    end
  endtask

  // receiver
  initial begin
    int stall;
    int long_hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        out_ready_i <= 1'b0;
        long_hold = 0;
        while (long_hold < 300) begin
          @(negedge clk_i);
          long_hold++;
        end
        out_ready_i <= 1'b1;
        wait (!hold_receiver);
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      received++;
      if (expected_angles.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
      end else begin
        want = expected_angles.pop_front();
        if (pitch_clamped_o) clamp_hits++;
        if (roll_angle_o !== want.roll || pitch_angle_o !== want.pitch ||
            yaw_angle_o !== want.yaw || pitch_clamped_o !== want.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d: exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
                     received, want.roll, want.pitch, want.yaw, want.clamped,
                     roll_angle_o, pitch_angle_o, yaw_angle_o, pitch_clamped_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** quaternion_to_euler_angles: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_backpressure();
    test_random();
    finish_sending();
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d quaternions, checked %0d angle sets, %0d with pitch clamped",
             sent, received, clamp_hits);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("** quaternion_to_euler_angles: PASSED **");
    end else begin
      $display("%0d mismatches, %0d unexpected transfers", mismatches, unexpected);
      $display("** quaternion_to_euler_angles: FAILED **");
    end
    $finish;
  end

endmodule

/* quaternion_to_euler_angles.f */
src/qte_pkg.sv
src/qte_sqrt_cell.sv
src/qte_cordic_cell.sv
src/quaternion_to_euler_angles.sv
dv/testbench.sv
